FILE: rtl/road_strip_zipper_triangulator_assert.svh
// Assertion macros shared by the checker of the road strip zipper triangulator.
`ifndef ROAD_STRIP_ZIPPER_TRIANGULATOR_ASSERT_SVH
`define ROAD_STRIP_ZIPPER_TRIANGULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSZT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rszt: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSZT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rszt: next-cycle check failed");

`endif

FILE: rtl/rszt_pkg.sv
// Shared types and constants of the road strip zipper triangulator.
`timescale 1ns / 1ps

package rszt_pkg;

    localparam int MAX_SIDE_SEGMENTS_DEF = 16;

    localparam int WIDTH_W   = 16;
    localparam int INDEX_W   = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    localparam logic [WIDTH_W-1:0] DIVIDE_RESET = 16'd256;
    localparam logic [WIDTH_W-1:0] MIN_STEP     = 16'd3;
    localparam logic [WIDTH_W-1:0] TINY_WIDTH   = 16'd26;

    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDE_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_INDEX    = 8'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_SETUP,
        S_LINIT,
        S_LEFT,
        S_RINIT,
        S_RIGHT,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic count;
        logic setup;
        logic band_init;
        logic band_right;
        logic emit;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic count_done;
        logic do_tri;
        logic band_done;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/rszt_ctrl.sv
// Sequencer of the road strip zipper triangulator: one row at a time.
`timescale 1ns / 1ps

module rszt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rszt_pkg::t_sts i_sts,
    output rszt_pkg::t_cmd o_cmd
);

    rszt_pkg::t_state r_state;
    rszt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rszt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rszt_pkg::S_IDLE: begin
                if (i_in_valid) n_state = rszt_pkg::S_COUNT;
            end
            rszt_pkg::S_COUNT: begin
                if (i_sts.count_done) n_state = rszt_pkg::S_SETUP;
            end
            rszt_pkg::S_SETUP: begin
                n_state = i_sts.do_tri ? rszt_pkg::S_LINIT : rszt_pkg::S_COMMIT;
            end
            rszt_pkg::S_LINIT: n_state = rszt_pkg::S_LEFT;
            rszt_pkg::S_LEFT: begin
                if (i_sts.band_done) n_state = rszt_pkg::S_RINIT;
            end
            rszt_pkg::S_RINIT: n_state = rszt_pkg::S_RIGHT;
            rszt_pkg::S_RIGHT: begin
                if (i_sts.band_done) n_state = rszt_pkg::S_COMMIT;
            end
            rszt_pkg::S_COMMIT: n_state = rszt_pkg::S_IDLE;
            default: n_state = rszt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        case (r_state)
            rszt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            rszt_pkg::S_COUNT: o_cmd.count = 1'b1;
            rszt_pkg::S_SETUP: o_cmd.setup = 1'b1;
            rszt_pkg::S_LINIT: o_cmd.band_init = 1'b1;
            rszt_pkg::S_LEFT: begin
                o_cmd.emit = !i_sts.band_done && i_sts.out_free;
            end
            rszt_pkg::S_RINIT: begin
                o_cmd.band_init  = 1'b1;
                o_cmd.band_right = 1'b1;
            end
            rszt_pkg::S_RIGHT: begin
                o_cmd.band_right = 1'b1;
                o_cmd.emit       = !i_sts.band_done && i_sts.out_free;
            end
            rszt_pkg::S_COMMIT: o_cmd.commit = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: rtl/rszt_dp.sv
// Datapath of the road strip zipper triangulator: counts, row state and band merge.
`timescale 1ns / 1ps

module rszt_dp #(
    parameter int MAX_SIDE_SEGMENTS = rszt_pkg::MAX_SIDE_SEGMENTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [rszt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rszt_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  logic [rszt_pkg::WIDTH_W-1:0]       i_left_width,
    input  logic [rszt_pkg::WIDTH_W-1:0]       i_right_width,
    input  logic                               i_start_road,
    input  rszt_pkg::t_cmd                     i_cmd,
    output rszt_pkg::t_sts                     o_sts,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [rszt_pkg::INDEX_W-1:0]       o_vertex_a,
    output logic [rszt_pkg::INDEX_W-1:0]       o_vertex_b,
    output logic [rszt_pkg::INDEX_W-1:0]       o_vertex_c,
    output logic                               o_last_triangle
);

    localparam int WW = rszt_pkg::WIDTH_W;
    localparam int IW = rszt_pkg::INDEX_W;
    localparam int CW = $clog2(MAX_SIDE_SEGMENTS + 1);
    // Holds (count + 1) * step for any count up to the maximum.
    localparam int OW = WW + $clog2(MAX_SIDE_SEGMENTS + 2);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SIDE_SEGMENTS);

    logic [WW-1:0] r_divide_length;
    logic [IW-1:0] r_base_index;

    logic [WW-1:0] r_lw_in;
    logic [WW-1:0] r_rw_in;
    logic          r_start;
    logic [OW-1:0] r_lacc;
    logic [OW-1:0] r_racc;
    logic [CW-1:0] r_lcnt;
    logic [CW-1:0] r_rcnt;

    logic [IW-1:0] r_cur;
    logic [IW-1:0] r_pa;
    logic [IW-1:0] r_pb;
    logic [CW-1:0] r_i0;
    logic [CW-1:0] r_i1;
    logic [OW-1:0] r_off0;
    logic [OW-1:0] r_off1;

    logic          r_have_prev;
    logic [IW-1:0] r_prev_start;
    logic [WW-1:0] r_prev_lw;
    logic [WW-1:0] r_prev_rw;
    logic [CW-1:0] r_prev_lc;
    logic [CW-1:0] r_prev_rc;

    logic          r_ovalid;
    logic [IW-1:0] r_ova;
    logic [IW-1:0] r_ovb;
    logic [IW-1:0] r_ovc;
    logic          r_olast;

    logic [WW-1:0] w_step;
    logic [OW-1:0] w_step_ext;
    logic          w_ldone;
    logic          w_rdone;
    logic [WW-1:0] w_lw_eff;
    logic [WW-1:0] w_rw_eff;
    logic          w_zero_row;

    logic [CW-1:0] w_cnt0;
    logic [CW-1:0] w_cnt1;
    logic [WW-1:0] w_w0;
    logic [WW-1:0] w_w1;
    logic [OW-1:0] w_m0;
    logic [OW-1:0] w_m1;
    logic          w_ex0;
    logic          w_ex1;
    logic          w_take0;
    logic [IW-1:0] w_pa_nx;
    logic [IW-1:0] w_pb_nx;
    logic [CW-1:0] w_i0_nx;
    logic [CW-1:0] w_i1_nx;
    logic          w_right_empty;
    logic          w_last;

    assign w_step     = (r_divide_length < rszt_pkg::MIN_STEP) ? rszt_pkg::MIN_STEP
                                                               : r_divide_length;
    assign w_step_ext = OW'(w_step);
    assign w_zero_row = (i_left_width == '0) && (i_right_width == '0);

    // A side stops at the first multiple of the step that reaches its width,
    // or at the segment limit, where the width is clamped to the accumulator.
    assign w_ldone  = (r_lcnt == CNT_MAX) || (r_lacc >= OW'(r_lw_in));
    assign w_rdone  = (r_rcnt == CNT_MAX) || (r_racc >= OW'(r_rw_in));
    assign w_lw_eff = (r_lacc < OW'(r_lw_in)) ? r_lacc[WW-1:0] : r_lw_in;
    assign w_rw_eff = (r_racc < OW'(r_rw_in)) ? r_racc[WW-1:0] : r_rw_in;

    assign w_cnt0 = i_cmd.band_right ? r_prev_rc : r_prev_lc;
    assign w_w0   = i_cmd.band_right ? r_prev_rw : r_prev_lw;
    assign w_cnt1 = i_cmd.band_right ? r_rcnt    : r_lcnt;
    assign w_w1   = i_cmd.band_right ? w_rw_eff  : w_lw_eff;

    assign w_m0    = (r_off0 < OW'(w_w0)) ? r_off0 : OW'(w_w0);
    assign w_m1    = (r_off1 < OW'(w_w1)) ? r_off1 : OW'(w_w1);
    assign w_ex0   = r_i0 >= w_cnt0;
    assign w_ex1   = r_i1 >= w_cnt1;
    // On a tie the previous row advances first.
    assign w_take0 = !w_ex0 && (w_ex1 || (w_m0 <= w_m1));

    assign w_pa_nx = i_cmd.band_right ? r_pa + 32'd1 : r_pa - 32'd1;
    assign w_pb_nx = i_cmd.band_right ? r_pb + 32'd1 : r_pb - 32'd1;
    assign w_i0_nx = r_i0 + CW'(w_take0);
    assign w_i1_nx = r_i1 + CW'(!w_take0);

    assign w_right_empty = (r_prev_rc == '0) && (r_rcnt == '0);
    assign w_last = (w_i0_nx >= w_cnt0) && (w_i1_nx >= w_cnt1)
                    && (i_cmd.band_right || w_right_empty);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divide_length <= rszt_pkg::DIVIDE_RESET;
            r_base_index    <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rszt_pkg::CFG_DIVIDE_LENGTH: r_divide_length <= i_cfg_data[WW-1:0];
                rszt_pkg::CFG_BASE_INDEX:    r_base_index    <= i_cfg_data[IW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lw_in <= w_zero_row ? rszt_pkg::TINY_WIDTH : i_left_width;
            r_rw_in <= w_zero_row ? rszt_pkg::TINY_WIDTH : i_right_width;
            r_start <= i_start_road;
            r_lacc  <= '0;
            r_racc  <= '0;
            r_lcnt  <= '0;
            r_rcnt  <= '0;
        end else if (i_cmd.count) begin
            if (!w_ldone) begin
                r_lacc <= r_lacc + w_step_ext;
                r_lcnt <= r_lcnt + CW'(1);
            end
            if (!w_rdone) begin
                r_racc <= r_racc + w_step_ext;
                r_rcnt <= r_rcnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_cur <= r_have_prev
                     ? r_prev_start + IW'(r_prev_lc) + IW'(r_prev_rc) + 32'd1
                     : r_base_index;
        end
        if (i_cmd.band_init) begin
            r_pa   <= r_prev_start + IW'(r_prev_lc);
            r_pb   <= r_cur + IW'(r_lcnt);
            r_i0   <= '0;
            r_i1   <= '0;
            r_off0 <= w_step_ext;
            r_off1 <= w_step_ext;
        end else if (i_cmd.emit) begin
            if (w_take0) begin
                r_pa   <= w_pa_nx;
                r_i0   <= w_i0_nx;
                r_off0 <= r_off0 + w_step_ext;
            end else begin
                r_pb   <= w_pb_nx;
                r_i1   <= w_i1_nx;
                r_off1 <= r_off1 + w_step_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (i_cmd.commit) begin
            r_have_prev <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_prev_start <= r_cur;
            r_prev_lw    <= w_lw_eff;
            r_prev_rw    <= w_rw_eff;
            r_prev_lc    <= r_lcnt;
            r_prev_rc    <= r_rcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ova   <= r_pa;
            r_ovb   <= r_pb;
            r_ovc   <= w_take0 ? w_pa_nx : w_pb_nx;
            r_olast <= w_last;
        end
    end

    assign o_sts.count_done = w_ldone && w_rdone;
    assign o_sts.do_tri     = r_have_prev && !r_start;
    assign o_sts.band_done  = w_ex0 && w_ex1;
    assign o_sts.out_free   = !r_ovalid || i_out_ready;

    assign o_out_valid     = r_ovalid;
    assign o_vertex_a      = r_ova;
    assign o_vertex_b      = r_ovb;
    assign o_vertex_c      = r_ovc;
    assign o_last_triangle = r_olast;

endmodule

FILE: rtl/road_strip_zipper_triangulator.sv
// Top level of the road strip zipper triangulator.
//
//  channel   direction  handshake                  payload
//  s_axis    in         i_s_axis_tvalid/o_..tready tdata: left, right width; tuser: start
//  m_axis    out        o_m_axis_tvalid/i_..tready tdata: vertex a, b, c; tlast: last tri
//  cfg       in         i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
//
// One row is taken at a time. A row passes through the segment counter (both sides in
// parallel), then setup, band turnaround and commit, and returns to idle to take the
// next row. The merge emits one triangle per cycle while the output register is free,
// at most 4 * MAX_SIDE_SEGMENTS triangles per row.
// The output register paces the triangles, so a stalled m_axis holds the merge in place.
// Reset is synchronous and active low and needs no clearing pass.
`timescale 1ns / 1ps

module road_strip_zipper_triangulator #(
    parameter int MAX_SIDE_SEGMENTS = rszt_pkg::MAX_SIDE_SEGMENTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [15:0] left_width, [31:16] right_width
    input  logic [31:0]                    i_s_axis_tdata,
    // [0] start_road
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [31:0] vertex_a, [63:32] vertex_b, [95:64] vertex_c
    output logic [95:0]                    o_m_axis_tdata,
    output logic                           o_m_axis_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rszt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rszt_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    rszt_pkg::t_cmd w_cmd;
    rszt_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    rszt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rszt_dp #(
        .MAX_SIDE_SEGMENTS (MAX_SIDE_SEGMENTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_left_width    (i_s_axis_tdata[15:0]),
        .i_right_width   (i_s_axis_tdata[31:16]),
        .i_start_road    (i_s_axis_tuser),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_vertex_a      (o_m_axis_tdata[31:0]),
        .o_vertex_b      (o_m_axis_tdata[63:32]),
        .o_vertex_c      (o_m_axis_tdata[95:64]),
        .o_last_triangle (o_m_axis_tlast)
    );

endmodule

FILE: rtl/rszt_chk.sv
// Port-level checker of the road strip zipper triangulator and its bind.
`timescale 1ns / 1ps
`include "road_strip_zipper_triangulator_assert.svh"

module rszt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [95:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    logic        w_row_xfer;
    logic        w_out_stall;
    logic [96:0] w_out_beat;
    logic [31:0] w_va;
    logic [31:0] w_vb;
    logic [31:0] w_vc;
    logic        w_tri_ok;

    assign w_row_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_out_beat  = {o_m_axis_tlast, o_m_axis_tdata};
    assign w_va        = o_m_axis_tdata[31:0];
    assign w_vb        = o_m_axis_tdata[63:32];
    assign w_vc        = o_m_axis_tdata[95:64];
    assign w_tri_ok    = (w_vc == w_va - 32'd1) || (w_vc == w_va + 32'd1)
                         || (w_vc == w_vb - 32'd1) || (w_vc == w_vb + 32'd1);

    // A stalled triangle keeps its valid and its payload.
    `RSZT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_m_axis_tvalid && $stable(w_out_beat))

    // A row transfer always starts a busy period.
    `RSZT_ASSERT_NXT(a_busy_after_row, i_clk, i_rst_n, w_row_xfer, !o_s_axis_tready)

    // The third vertex is always the neighbor of the first or second one.
    `RSZT_ASSERT_IMP(a_tri_shape, i_clk, i_rst_n, o_m_axis_tvalid, w_tri_ok)

    // New triangles come only out of a row in progress.
    `RSZT_ASSERT_IMP(a_emit_busy, i_clk, i_rst_n, $rose(o_m_axis_tvalid), !$past(o_s_axis_tready))

endmodule

bind road_strip_zipper_triangulator rszt_chk u_rszt_chk (.*);

FILE: tb/sv/rszt_triangle_checker.sv
// Checker that predicts and compares the triangle stream of the road strip zipper triangulator.
`timescale 1ns / 1ps

module rszt_triangle_checker #(
    parameter int SIDE_MAX = rszt_pkg::MAX_SIDE_SEGMENTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_row_valid,
    input  logic                           i_row_ready,
    input  logic [31:0]                    i_row_data,
    input  logic                           i_row_user,
    input  logic                           i_tri_valid,
    input  logic                           i_tri_ready,
    input  logic [95:0]                    i_tri_data,
    input  logic                           i_tri_last,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [rszt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rszt_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int                             o_failures,
    output int                             o_outstanding,
    output int                             o_checked
);

    typedef struct packed {
        logic [31:0] vertex_a;
        logic [31:0] vertex_b;
        logic [31:0] vertex_c;
        logic        last_triangle;
    } t_triangle;

    // Mirror of the block's registers and row history.
    logic [15:0] divide_len;
    logic [31:0] first_vertex;
    bit          have_prev;
    logic [31:0] prev_start;
    logic [15:0] prev_lw;
    logic [15:0] prev_rw;
    int unsigned prev_lc;
    int unsigned prev_rc;

    t_triangle   tri_q[$];
    t_triangle   head;
    int          failures = 0;
    int          checked = 0;

    function automatic logic [31:0] lane_offset(input int unsigned k, input logic [31:0] step,
                                                input logic [15:0] w);
        logic [31:0] v;
        v = (k + 1) * step;
        return (v < {16'd0, w}) ? v : {16'd0, w};
    endfunction

    // Merge the offsets of one side of the previous row with those of the current row.
    // On equal offsets the previous row moves first.
    task automatic zip_band(input logic [31:0] b0, input int unsigned n0, input logic [15:0] w0,
                            input logic [31:0] b1, input int unsigned n1, input logic [15:0] w1,
                            input logic [31:0] step, input bit to_left);
        int unsigned k0;
        int unsigned k1;
        bit          old_side;
        t_triangle   t;
        k0 = 0;
        k1 = 0;
        while (k0 < n0 || k1 < n1) begin
            if (k0 >= n0) begin
                old_side = 1'b0;
            end else if (k1 >= n1) begin
                old_side = 1'b1;
            end else begin
                old_side = lane_offset(k0, step, w0) <= lane_offset(k1, step, w1);
            end
            t.vertex_a = to_left ? b0 - k0 : b0 + k0;
            t.vertex_b = to_left ? b1 - k1 : b1 + k1;
            if (old_side) begin
                t.vertex_c = to_left ? b0 - (k0 + 1) : b0 + (k0 + 1);
                k0++;
            end else begin
                t.vertex_c = to_left ? b1 - (k1 + 1) : b1 + (k1 + 1);
                k1++;
            end
            t.last_triangle = 1'b0;
            tri_q.insert(tri_q.size(), t);
        end
    endtask

    task automatic predict_row(input logic [15:0] lw_in, input logic [15:0] rw_in,
                               input bit new_road);
        logic [31:0] step;
        logic [31:0] cap;
        logic [31:0] lw;
        logic [31:0] rw;
        logic [31:0] cur;
        logic [31:0] c0;
        int unsigned lc;
        int unsigned rc;
        int          queued;
        t_triangle   t;
        step = (divide_len < rszt_pkg::MIN_STEP) ? {16'd0, rszt_pkg::MIN_STEP}
                                                 : {16'd0, divide_len};
        cap  = step * SIDE_MAX;
        lw   = {16'd0, lw_in};
        rw   = {16'd0, rw_in};
        if (lw == 0 && rw == 0) begin
            lw = {16'd0, rszt_pkg::TINY_WIDTH};
            rw = {16'd0, rszt_pkg::TINY_WIDTH};
        end
        if (lw > cap) lw = cap;
        if (rw > cap) rw = cap;
        lc  = lw / step + ((lw % step) != 0 ? 1 : 0);
        rc  = rw / step + ((rw % step) != 0 ? 1 : 0);
        cur = have_prev ? prev_start + prev_lc + 1 + prev_rc : first_vertex;
        if (have_prev && !new_road) begin
            queued = tri_q.size();
            c0     = prev_start + prev_lc;
            zip_band(c0, prev_lc, prev_lw, cur + lc, lc, lw[15:0], step, 1'b1);
            zip_band(c0, prev_rc, prev_rw, cur + lc, rc, rw[15:0], step, 1'b0);
            if (tri_q.size() > queued) begin
                t = tri_q[tri_q.size() - 1];
                t.last_triangle = 1'b1;
                tri_q[tri_q.size() - 1] = t;
            end
        end
        have_prev  = 1'b1;
        prev_start = cur;
        prev_lw    = lw[15:0];
        prev_rw    = rw[15:0];
        prev_lc    = lc;
        prev_rc    = rc;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
                     $time, field, want, want, got, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            divide_len   = rszt_pkg::DIVIDE_RESET;
            first_vertex = '0;
            have_prev    = 1'b0;
            prev_start   = '0;
            prev_lw      = '0;
            prev_rw      = '0;
            prev_lc      = 0;
            prev_rc      = 0;
            tri_q.delete();
        end else begin
            if (i_tri_valid && i_tri_ready) begin
                if (tri_q.size() == 0) begin
                    failures++;
                    $display("%0t: triangle %0d %0d %0d last %0b arrived, none expected",
                             $time, i_tri_data[31:0], i_tri_data[63:32],
                             i_tri_data[95:64], i_tri_last);
                end else begin
                    head = tri_q.pop_front();
                    check_field("vertex_a", head.vertex_a, i_tri_data[31:0]);
                    check_field("vertex_b", head.vertex_b, i_tri_data[63:32]);
                    check_field("vertex_c", head.vertex_c, i_tri_data[95:64]);
                    check_field("last_triangle", {31'd0, head.last_triangle},
                                {31'd0, i_tri_last});
                    checked++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == rszt_pkg::CFG_DIVIDE_LENGTH) begin
                    divide_len = i_cfg_data[15:0];
                end else if (i_cfg_index == rszt_pkg::CFG_BASE_INDEX) begin
                    first_vertex = i_cfg_data;
                end
            end
            if (i_row_valid && i_row_ready) begin
                predict_row(i_row_data[15:0], i_row_data[31:16], i_row_user);
            end
        end
        o_failures    <= failures;
        o_outstanding <= tri_q.size();
        o_checked     <= checked;
    end

endmodule

FILE: tb/sv/tb.sv
// Testbench top for the road strip zipper triangulator: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int SIDE_MAX      = rszt_pkg::MAX_SIDE_SEGMENTS_DEF;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ROWS_PER_PHASE = 17;
    // An index past the end of the register map; the block must ignore it.
    localparam logic [rszt_pkg::CFG_IDX_W-1:0] CFG_NO_SUCH_REG = 8'd2;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [31:0]                    s_tdata   = '0;
    logic                           s_tuser   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b1;
    logic [95:0]                    m_tdata;
    logic                           m_tlast;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [rszt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rszt_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

    int failures;
    int outstanding;
    int triangles_checked;
    int cycles      = 0;
    int rows_sent   = 0;
    int road_starts = 0;
    int reg_writes  = 0;
    bit steady      = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    road_strip_zipper_triangulator #(
        .MAX_SIDE_SEGMENTS(SIDE_MAX)
    ) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    rszt_triangle_checker #(
        .SIDE_MAX(SIDE_MAX)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_row_valid   (s_tvalid),
        .i_row_ready   (s_tready),
        .i_row_data    (s_tdata),
        .i_row_user    (s_tuser),
        .i_tri_valid   (m_tvalid),
        .i_tri_ready   (m_tready),
        .i_tri_data    (m_tdata),
        .i_tri_last    (m_tlast),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_failures    (failures),
        .o_outstanding (outstanding),
        .o_checked     (triangles_checked)
    );

    // The triangle sink stalls about 30 percent of the time outside the steady stretch.
    always @(posedge clk) begin
        m_tready <= steady || ($urandom_range(99) >= 30);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d triangles still due.",
                     cycles, outstanding);
            $display("FAIL road_strip_zipper_triangulator");
            $finish;
        end
    end

    task automatic write_reg(input logic [rszt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic send_row(input logic [15:0] lw, input logic [15:0] rw, input bit new_road);
        if (!steady && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            // Mostly short gaps, now and then one that spans a whole row of work.
            if ($urandom_range(7) == 0) repeat ($urandom_range(10, 90)) @(posedge clk);
            else repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rw, lw};
        s_tuser  <= new_road;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        rows_sent++;
        if (new_road) road_starts++;
    endtask

    // Hold off the sender until every triangle has been taken, then let any row
    // that produces nothing finish inside the block.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_width(input int unsigned step);
        int unsigned span;
        span = step * (SIDE_MAX + 1);
        if (span > 65535) span = 65535;
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'($urandom());
            2: return 16'(step * $urandom_range(1, SIDE_MAX));
            default: return 16'($urandom_range(1, span));
        endcase
    endfunction

    initial begin
        logic [15:0] div_plan [6];
        logic [15:0] div_now;
        int unsigned step_eff;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows. The first setting is below the minimum step, so step 3 applies,
        // and the start index sits just below the wrap point.
        write_reg(rszt_pkg::CFG_BASE_INDEX, 32'hFFFF_FFF0);
        write_reg(rszt_pkg::CFG_DIVIDE_LENGTH, {16'($urandom()), 16'd0});
        send_row(16'd0, 16'd0, 1'b1);
        send_row(16'hFFFF, 16'hFFFF, 1'b0);
        send_row(16'd48, 16'd48, 1'b0);
        send_row(16'd0, 16'd5, 1'b0);
        send_row(16'd7, 16'd0, 1'b0);
        send_row(16'd0, 16'd0, 1'b0);
        send_row(16'd1, 16'd2, 1'b1);
        send_row(16'd1, 16'd1, 1'b0);

        // Widest step, changed in the middle of a road.
        settle();
        write_reg(rszt_pkg::CFG_DIVIDE_LENGTH, {16'($urandom()), 16'hFFFF});
        send_row(16'hFFFF, 16'hFFFF, 1'b0);
        send_row(16'hFFFF, 16'd1, 1'b0);
        send_row(16'd0, 16'd0, 1'b0);
        send_row(16'h8000, 16'h0001, 1'b1);
        send_row(16'h7FFF, 16'hFFFE, 1'b0);

        // One metre step; the start index write after the first row has no effect.
        settle();
        write_reg(rszt_pkg::CFG_DIVIDE_LENGTH, {16'($urandom()), 16'd256});
        write_reg(rszt_pkg::CFG_BASE_INDEX, $urandom());
        write_reg(CFG_NO_SUCH_REG, $urandom());
        send_row(16'h1000, 16'h1000, 1'b0);
        send_row(16'h0F80, 16'h0100, 1'b0);
        send_row(16'h0180, 16'h0C00, 1'b0);
        send_row(16'h0100, 16'h0100, 1'b0);
        send_row(16'hFFFF, 16'h0000, 1'b0);

        settle();
        write_reg(rszt_pkg::CFG_DIVIDE_LENGTH, {16'($urandom()), 16'd2});
        send_row(16'd50, 16'd49, 1'b0);
        send_row(16'd3, 16'd3, 1'b0);

        // Random rows in phases of one step each; the fourth phase runs without idling.
        div_plan = '{16'd10, 16'd3, 16'd1, 16'd40, 16'd256, 16'($urandom_range(4, 4000))};
        for (int p = 0; p < 6; p++) begin
            settle();
            div_now  = div_plan[p];
            step_eff = 32'((div_now < rszt_pkg::MIN_STEP) ? rszt_pkg::MIN_STEP : div_now);
            write_reg(rszt_pkg::CFG_DIVIDE_LENGTH, {16'($urandom()), div_now});
            steady <= (p == 3);
            for (int r = 0; r < ROWS_PER_PHASE; r++) begin
                if (p == 1 && r == 10) settle();
                send_row(pick_width(step_eff), pick_width(step_eff), $urandom_range(9) == 0);
            end
        end
        steady <= 1'b0;
        settle();

        $display("Sent %0d rows (%0d starting a road) and checked %0d triangles.",
                 rows_sent, road_starts, triangles_checked);
        $display("Made %0d register writes, steps from below the minimum to the widest.",
                 reg_writes);
        if (failures == 0) begin
            $display("PASS road_strip_zipper_triangulator");
        end else begin
            $display("FAIL road_strip_zipper_triangulator");
        end
        $finish;
    end

endmodule
